>>> rtl/sigmoid_neuron_accumulate_defines.svh
// Assertion macros shared by the sigmoid neuron RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef SIGMOID_NEURON_ACCUMULATE_DEFINES_SVH
`define SIGMOID_NEURON_ACCUMULATE_DEFINES_SVH

// Plain property, clocked on clk, off while in reset.
`define SNP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SNP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/snp_pkg.sv
// Package for the sigmoid neuron: widths, limits, sum struct, ROM builders.
// No dependencies.
`timescale 1ns / 1ps

package snp_pkg;

  localparam int SIGMOID_ENTRIES_DEF = 256;
  localparam int DATA_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Table spans -8..8 in Q16.24, i.e. +-2^27
  localparam int LIM_SHIFT = 27;
  localparam logic signed [ACC_W-1:0] LIM_Q24 = ACC_W'(64'sd1 <<< LIM_SHIFT);
  localparam int OFFS_W = LIM_SHIFT + 1;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    saturated;
  } snp_sum_t;

  // exp(-g) for g in Q.30 in [0,1], then squared three times: exp(-8g).
  function automatic logic [63:0] sig_exp_neg(input logic [63:0] g);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] N;
    acc  = ONE_Q30;
    term = ONE_Q30;
    for (N = 64'd1; N <= 64'd20; N++) begin
      term = ((term * g) >> 30) / N;
      if (N[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (int k = 0; k < 3; k++) begin
      acc = (acc * acc + (ONE_Q30 >> 1)) >> 30;
    end
    return acc;
  endfunction

  // Q0.16 sigmoid from t = exp(-|x|); pos selects 1/(1+t) over t/(1+t).
  function automatic logic [DATA_W-1:0] sig_value(input logic [63:0] t,
                                                  input logic        pos);
    logic [63:0] Den;
    logic [63:0] val;
    Den = ONE_Q30 + t;
    if (pos) begin
      val = ((64'd1 << 46) + (Den >> 1)) / Den;
    end else begin
      val = ((t << 16) + (Den >> 1)) / Den;
    end
    if (val > 64'd65535) begin
      val = 64'd65535;
    end
    return val[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/snp_in_if.sv
// Input channel of the sigmoid neuron: activation, weight, last marker.
// Depends on snp_pkg.
`timescale 1ns / 1ps

interface snp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [snp_pkg::DATA_W-1:0] activation;
  logic signed [snp_pkg::DATA_W-1:0] weight;
  logic                              last;

  modport source(output valid, activation, weight, last, input ready);
  modport sink(input valid, activation, weight, last, output ready);
endinterface

>>> rtl/snp_out_if.sv
// Result channel of the sigmoid neuron: neuron output and clip flag.
// Depends on snp_pkg.
`timescale 1ns / 1ps

interface snp_out_if;
  logic                       valid;
  logic                       ready;
  logic [snp_pkg::DATA_W-1:0] neuron_output;
  logic                       saturated;

  modport source(output valid, neuron_output, saturated, input ready);
  modport sink(input valid, neuron_output, saturated, output ready);
endinterface

>>> rtl/snp_mac.sv
// Multiply stage and saturating 40-bit accumulator of the sigmoid neuron.
// Depends on snp_pkg and sigmoid_neuron_accumulate_defines.svh.
`timescale 1ns / 1ps
`include "sigmoid_neuron_accumulate_defines.svh"

module snp_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_take,
  input  logic signed [snp_pkg::DATA_W-1:0] activation,
  input  logic signed [snp_pkg::DATA_W-1:0] weight,
  input  logic                              last,
  output logic                              sum_valid,
  output snp_pkg::snp_sum_t                 sum_out
);

  logic signed [snp_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                              prod_last_r;
  logic                              prod_valid_r;
  logic signed [snp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic                              clip_r, clip_nxt;
  snp_pkg::snp_sum_t                 sum_r, sum_nxt;
  logic                              sum_valid_r;

  logic signed [snp_pkg::ACC_W:0]    wide;
  logic signed [snp_pkg::ACC_W-1:0]  sat_sum;
  logic                              ovf;

  assign prod_nxt = activation * weight;

  always_comb begin
    wide = (snp_pkg::ACC_W + 1)'(acc_r) + (snp_pkg::ACC_W + 1)'(prod_r);
    ovf  = wide[snp_pkg::ACC_W] != wide[snp_pkg::ACC_W-1];
    if (ovf) begin
      sat_sum = wide[snp_pkg::ACC_W] ? snp_pkg::ACC_MIN : snp_pkg::ACC_MAX;
    end else begin
      sat_sum = wide[snp_pkg::ACC_W-1:0];
    end
    sum_nxt.sum       = sat_sum;
    sum_nxt.saturated = clip_r | ovf;
    // last item closes the vector: emit and start over from zero
    if (prod_last_r) begin
      acc_nxt  = '0;
      clip_nxt = 1'b0;
    end else begin
      acc_nxt  = sat_sum;
      clip_nxt = clip_r | ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
      acc_r        <= '0;
      clip_r       <= 1'b0;
    end else if (en) begin
      prod_valid_r <= in_take;
      sum_valid_r  <= prod_valid_r & prod_last_r;
      if (prod_valid_r) begin
        acc_r  <= acc_nxt;
        clip_r <= clip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r      <= prod_nxt;
      prod_last_r <= last;
      sum_r       <= sum_nxt;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum_out   = sum_r;

  `SNP_ASSERT_NEXT(a_acc_clear, en && prod_valid_r && prod_last_r, acc_r == '0 && !clip_r, "accumulator not cleared after last item")
  `SNP_ASSERT_NEXT(a_clip_hold, en && prod_valid_r && !prod_last_r && clip_r, clip_r, "clip flag dropped inside a vector")

endmodule

>>> rtl/snp_sigmoid.sv
// Table index stage and sigmoid ROM read into the result register.
// Depends on snp_pkg and sigmoid_neuron_accumulate_defines.svh.
`timescale 1ns / 1ps
`include "sigmoid_neuron_accumulate_defines.svh"

module snp_sigmoid #(
  parameter int SIGMOID_ENTRIES = snp_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       sum_valid,
  input  snp_pkg::snp_sum_t          sum_in,
  output logic                       out_valid,
  output logic [snp_pkg::DATA_W-1:0] neuron_output,
  output logic                       saturated
);

  localparam int IDX_W   = $clog2(SIGMOID_ENTRIES);
  localparam int SCALE_W = snp_pkg::OFFS_W + IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIGMOID_ENTRIES - 1);

  // Entry i stands for x = -8 + 16*i/SIGMOID_ENTRIES.
  logic [snp_pkg::DATA_W-1:0] rom [SIGMOID_ENTRIES];

  for (genvar i = 0; i < SIGMOID_ENTRIES; i++) begin : g_rom
    localparam longint D = 64'sd16 * longint'(i) - 64'sd8 * longint'(SIGMOID_ENTRIES);
    localparam logic [63:0] NUM = 64'((D < 0) ? -D : D);
    localparam logic [63:0] G_RAW = (NUM << 27) / SIGMOID_ENTRIES;
    localparam logic [63:0] G = (G_RAW > snp_pkg::ONE_Q30) ? snp_pkg::ONE_Q30 : G_RAW;
    assign rom[i] = snp_pkg::sig_value(snp_pkg::sig_exp_neg(G), D >= 0);
  end

  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       idx_sat_r;
  logic                       idx_valid_r;
  logic                       out_valid_r;
  logic [snp_pkg::DATA_W-1:0] out_data_r;
  logic                       out_sat_r;

  logic [snp_pkg::OFFS_W-1:0] offs;
  logic [SCALE_W-1:0]         scaled;
  logic [IDX_W:0]             idx_full;

  always_comb begin
    offs     = snp_pkg::OFFS_W'(sum_in.sum + snp_pkg::LIM_Q24);
    scaled   = SCALE_W'(offs) * SCALE_W'(SIGMOID_ENTRIES);
    idx_full = scaled[SCALE_W-1:snp_pkg::OFFS_W];
    if (sum_in.sum < -snp_pkg::LIM_Q24) begin
      idx_nxt = '0;
    end else if (sum_in.sum >= snp_pkg::LIM_Q24) begin
      idx_nxt = LAST_IDX;
    end else if (idx_full > (IDX_W + 1)'(LAST_IDX)) begin
      idx_nxt = LAST_IDX;
    end else begin
      idx_nxt = idx_full[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      idx_valid_r <= sum_valid;
      out_valid_r <= idx_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r      <= idx_nxt;
      idx_sat_r  <= sum_in.saturated;
      out_data_r <= rom[idx_r];
      out_sat_r  <= idx_sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign neuron_output = out_data_r;
  assign saturated     = out_sat_r;

  `SNP_ASSERT_NEXT(a_idx_to_out, en && idx_valid_r, out_valid_r, "indexed sum did not reach result register")

endmodule

>>> rtl/sigmoid_neuron_accumulate.sv
// Top level of the sigmoid neuron: MAC front end, sigmoid table back end.
// Throughput: one item per cycle; ready drops only while a result waits.
// Reset (rst_n low, synchronous) empties the pipe and zeroes the accumulator.
// Depends on snp_pkg, snp_in_if, snp_out_if, snp_mac, snp_sigmoid.
`timescale 1ns / 1ps
`include "sigmoid_neuron_accumulate_defines.svh"

module sigmoid_neuron_accumulate #(
  parameter int SIGMOID_ENTRIES = snp_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  snp_in_if.sink    in_ch,
  snp_out_if.source out_ch
);

  // Pipe:
  //   stage A  activation*weight registered (16x16 signed)
  //   stage B  40-bit saturating add into the accumulator; on a last item
  //            the sum and clip flag are latched and the accumulator clears
  //   stage C  sum -> table index (clamped to the -8..8 span)
  //   stage D  table read into the result register
  // Every stage advances together; the only hold-off comes from an untaken
  // result sitting in the result register.

  logic              en;
  logic              sum_valid;
  snp_pkg::snp_sum_t sum_bus;

  assign en          = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = en;

  snp_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_take    (in_ch.valid),
    .activation (in_ch.activation),
    .weight     (in_ch.weight),
    .last       (in_ch.last),
    .sum_valid  (sum_valid),
    .sum_out    (sum_bus)
  );

  snp_sigmoid #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_sigmoid (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .sum_valid     (sum_valid),
    .sum_in        (sum_bus),
    .out_valid     (out_ch.valid),
    .neuron_output (out_ch.neuron_output),
    .saturated     (out_ch.saturated)
  );

  // A waiting result must hold off new items.
  `SNP_ASSERT(a_stall_blocks, !(out_ch.valid && !out_ch.ready) || !in_ch.ready, "input taken while result stalled")

endmodule

>>> test/testbench.sv
// Self-checking bench for sigmoid_neuron_accumulate: MAC, saturation, sigmoid lookup.
// Drives snp_in_if and drains snp_out_if; uses snp_pkg widths and accumulator limits.
`timescale 1ns / 1ps

module testbench;

  // ---------------------------------------------------------------------------
  // Sizes and run limits
  // ---------------------------------------------------------------------------
  localparam int TABLE_SIZE      = 256;   // sigmoid table depth, passed to the dut
  localparam int DW              = snp_pkg::DATA_W;
  localparam int RANDOM_PAIRS    = 70;    // random part stops after this many pairs
  localparam int SQUEEZE_AT      = 20;    // random pairs sent before the long hold-off
  localparam int HOLD_OFF_CYCLES = 200;   // long receiver stall, fills the pipe
  localparam int IDLE_LIMIT      = 2000;  // watchdog: cycles with no handshake at all
  localparam int DRAIN_TAIL      = 12;    // covers the pipe depth, plus extra for strays
  localparam int MAX_PRINTS      = 30;

  // Accumulator rails and the +-8.0 table span, both in Q16.24
  localparam longint SUM_HI    = longint'(snp_pkg::ACC_MAX);
  localparam longint SUM_LO    = longint'(snp_pkg::ACC_MIN);
  localparam longint HALF_SPAN = longint'(1) <<< 27;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [DW-1:0] neuron_output;
    logic          saturated;
  } neuron_res_t;

  // Where a directed row takes its expected output from
  typedef enum logic [0:0] {GOLD_MODEL, GOLD_TYPED} golden_t;

  typedef struct packed {
    logic signed [DW-1:0] activation;
    logic signed [DW-1:0] weight;
    logic                 last;
    logic [9:0]           reps;       // same pair sent this many times
    golden_t              src;
    logic [DW-1:0]        typed_out;
    logic                 typed_sat;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Directed table. Q4.12: 0x1000 = 1.0, 0x8000 = -8.0, 0x7FFF ~ 8.0.
  // Only obvious outputs are typed in (zero sum gives exactly 0.5 = 0x8000);
  // all other rows go through the predictor.
  // ---------------------------------------------------------------------------
  localparam int NUM_ROWS = 18;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // zero sum right after reset: midpoint of the table
    '{16'h0000, 16'h0000, 1'b1, 10'd1,   GOLD_TYPED, 16'h8000, 1'b0},
    // bias neuron 1.0 times weight 1.0
    '{16'h1000, 16'h1000, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // largest positive product (-8 * -8), clamps to the top entry
    '{16'h8000, 16'h8000, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    '{16'h7FFF, 16'h7FFF, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // most negative product, clamps to entry 0
    '{16'h8000, 16'h7FFF, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // sum exactly -8.0: lowest in-range index
    '{16'h1000, 16'h8000, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // sum exactly +8.0: first value that clamps high
    '{16'h8000, 16'hF000, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // +8.0 minus one LSB: top in-range index
    '{16'h8000, 16'hF000, 1'b0, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    '{16'h0001, 16'hFFFF, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // one LSB either side of zero
    '{16'hFFFF, 16'h0001, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    '{16'h0001, 16'h0001, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // pairs without last produce nothing
    '{16'h0000, 16'h0000, 1'b0, 10'd3,   GOLD_MODEL, 16'h0000, 1'b0},
    // the zero pairs above and three more inputs form one vector closed by the bias term
    '{16'h0800, 16'h2000, 1'b0, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    '{16'h1000, 16'hF800, 1'b0, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    '{16'h1000, 16'h0400, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // 514 * 2^30 runs past the positive rail (2^39 - 1)
    '{16'h8000, 16'h8000, 1'b0, 10'd514, GOLD_MODEL, 16'h0000, 1'b0},
    // pull back off the rail with a negative product: clip still reported
    '{16'h8000, 16'h7FFF, 1'b1, 10'd1,   GOLD_MODEL, 16'h0000, 1'b0},
    // clip flag and sum must be cleared by the previous last
    '{16'h0000, 16'h0000, 1'b1, 10'd1,   GOLD_TYPED, 16'h8000, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, dut
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  snp_in_if  in_ch();
  snp_out_if out_ch();

  sigmoid_neuron_accumulate #(
    .SIGMOID_ENTRIES(TABLE_SIZE)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the sigmoid table, running sum, clip flag
  // ---------------------------------------------------------------------------
  logic [DW-1:0] sig_table [TABLE_SIZE];
  longint        neuron_sum;
  bit            neuron_clip;

  neuron_res_t   pending_outputs[$];   // expected results, oldest first

  // Bookkeeping shared by the processes
  bit  no_idle;        // both sides run flat out while set
  bit  squeeze_req;    // asks the receiver for one long hold-off
  int  mismatches;
  int  pairs_sent;
  int  vectors_sent;
  int  outputs_checked;
  int  clipped_outputs;
  int  idx_lo;
  int  idx_hi;

  // exp(-g), g in Q.30 within [0,1], Taylor series through g^20
  function automatic longint unsigned exp_neg_q30(input longint unsigned g);
    longint unsigned acc;
    longint unsigned term;
    acc  = Q30_ONE;
    term = Q30_ONE;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * g) >> 30) / longint'(n);
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // Entry i stands for x = -8 + 16*i/TABLE_SIZE; t = exp(-|x|) via exp(-|x|/8)^8
  function automatic void build_sigmoid_table();
    longint          d;
    longint unsigned mag;
    longint unsigned g;
    longint unsigned t;
    longint unsigned den;
    longint unsigned val;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      d   = longint'(16 * i) - longint'(8 * TABLE_SIZE);
      mag = (d < 0) ? longint'(-d) : longint'(d);
      g   = (mag << 27) / longint'(TABLE_SIZE);
      if (g > Q30_ONE) begin
        g = Q30_ONE;
      end
      t = exp_neg_q30(g);
      for (int k = 0; k < 3; k++) begin
        t = (t * t + (Q30_ONE >> 1)) >> 30;
      end
      den = Q30_ONE + t;
      if (d >= 0) begin
        val = ((64'd1 << 46) + (den >> 1)) / den;
      end else begin
        val = ((t << 16) + (den >> 1)) / den;
      end
      if (val > 64'd65535) begin
        val = 64'd65535;
      end
      sig_table[i] = val[DW-1:0];
    end
  endfunction

  // One accepted pair: MAC with saturation; on last, look up and clear.
  // Returns 1 when the pair yields an output.
  function automatic bit accumulate_pair(input logic signed [DW-1:0] act,
                                         input logic signed [DW-1:0] wgt,
                                         input logic                 last,
                                         output neuron_res_t         res);
    longint s;
    int     idx;
    res = '0;
    s   = neuron_sum + longint'(act) * longint'(wgt);
    if (s > SUM_HI) begin
      s           = SUM_HI;
      neuron_clip = 1'b1;
    end
    if (s < SUM_LO) begin
      s           = SUM_LO;
      neuron_clip = 1'b1;
    end
    neuron_sum = s;
    if (!last) begin
      return 1'b0;
    end
    if (s < -HALF_SPAN) begin
      idx = 0;
    end else if (s >= HALF_SPAN) begin
      idx = TABLE_SIZE - 1;
    end else begin
      idx = int'(((s + HALF_SPAN) * longint'(TABLE_SIZE)) >>> 28);
    end
    if (idx >= TABLE_SIZE) begin
      idx = TABLE_SIZE - 1;
    end
    idx_lo            = (idx < idx_lo) ? idx : idx_lo;
    idx_hi            = (idx > idx_hi) ? idx : idx_hi;
    res.neuron_output = sig_table[idx];
    res.saturated     = neuron_clip;
    neuron_sum        = 0;
    neuron_clip       = 1'b0;
    return 1'b1;
  endfunction

  // Gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r < 10) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Q4.12 operand: mostly small enough that sums land inside +-8,
  // the rest edge values or the full 16-bit range
  function automatic logic [DW-1:0] pick_fixed();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 8192);
        return DW'(v - 4096);
      end
      4, 5, 6: begin
        v = $urandom_range(0, 16384);
        return DW'(v - 8192);
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // Offer one pair at the falling edge, hold it until accepted, then maybe
  // drop valid for a gap. Valid stays high across back-to-back items.
  task automatic send_pair(input logic signed [DW-1:0] act,
                           input logic signed [DW-1:0] wgt,
                           input logic                 last,
                           input bit                   typed,
                           input neuron_res_t          typed_res);
    neuron_res_t res;
    int          gap;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.activation <= act;
    in_ch.weight     <= wgt;
    in_ch.last       <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    pairs_sent++;
    if (accumulate_pair(act, wgt, last, res)) begin
      if (typed) begin
        res = typed_res;
      end
      pending_outputs.push_back(res);
      vectors_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        // Sender keeps offering single-pair vectors; the dut must backpressure
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        squeeze_req   = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    neuron_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected output %h sat %b",
                                  out_ch.neuron_output, out_ch.saturated));
      end else begin
        want = pending_outputs.pop_front();
        outputs_checked++;
        if (want.saturated) begin
          clipped_outputs++;
        end
        if (out_ch.neuron_output !== want.neuron_output) begin
          report_mismatch($sformatf("output #%0d neuron_output %h, want %h",
                                    outputs_checked, out_ch.neuron_output,
                                    want.neuron_output));
        end
        if (out_ch.saturated !== want.saturated) begin
          report_mismatch($sformatf("output #%0d saturated %b, want %b",
                                    outputs_checked, out_ch.saturated,
                                    want.saturated));
        end
      end
    end
  end

  // Watchdog: counts idle cycles and ends the run at IDLE_LIMIT with no handshake
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Timeout: no handshake for %0d cycles, %0d outputs outstanding",
             IDLE_LIMIT, pending_outputs.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, random vectors, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    neuron_res_t typed_res;
    int          random_pairs;
    int          len;
    bit          squeeze_done;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.activation = '0;
    in_ch.weight     = '0;
    in_ch.last       = 1'b0;
    no_idle          = 1'b0;
    squeeze_req      = 1'b0;
    squeeze_done     = 1'b0;
    mismatches       = 0;
    pairs_sent       = 0;
    vectors_sent     = 0;
    outputs_checked  = 0;
    clipped_outputs  = 0;
    idx_lo           = TABLE_SIZE;
    idx_hi           = -1;
    random_pairs     = 0;
    neuron_sum       = 0;
    neuron_clip      = 1'b0;
    build_sigmoid_table();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (DIRECTED[r]) begin
      typed_res.neuron_output = DIRECTED[r].typed_out;
      typed_res.saturated     = DIRECTED[r].typed_sat;
      repeat (DIRECTED[r].reps) begin
        send_pair(DIRECTED[r].activation, DIRECTED[r].weight, DIRECTED[r].last,
                  DIRECTED[r].src == GOLD_TYPED, typed_res);
      end
    end

    // Random vectors, mostly short; one burst of single-pair vectors goes
    // against the long receiver hold-off
    while (random_pairs < RANDOM_PAIRS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (!squeeze_done && random_pairs >= SQUEEZE_AT) begin
        squeeze_done = 1'b1;
        no_idle      = 1'b1;
        squeeze_req  = 1'b1;
        repeat (16) begin
          send_pair(pick_fixed(), pick_fixed(), 1'b1, 1'b0, '0);
        end
        random_pairs += 16;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_pair(pick_fixed(), pick_fixed(), k == len - 1, 1'b0, '0);
        end
        random_pairs += len;
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain; the watchdog covers a result that never shows up
    while (pending_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Run: %0d pairs in %0d vectors, %0d outputs checked, %0d with clip set",
             pairs_sent, vectors_sent, outputs_checked, clipped_outputs);
    $display("Table indexes reached %0d..%0d of %0d, %0d mismatches",
             idx_lo, idx_hi, TABLE_SIZE, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/snp_pkg.sv
rtl/snp_in_if.sv
rtl/snp_out_if.sv
rtl/snp_mac.sv
rtl/snp_sigmoid.sv
rtl/sigmoid_neuron_accumulate.sv
test/testbench.sv
